/* rtl/prim_minimum_spanning_tree_defines.svh */
// Assertion macros shared by the RTL of the spanning tree block.
`ifndef PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PMST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pmst check failed");
// Next-cycle implication, checked out of reset.
`define PMST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pmst check failed");
`else
`define PMST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PMST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/pmst_pkg.sv */
package pmst_pkg;

    localparam int MAX_V       = 64;
    localparam int VTX_BITS    = $clog2(MAX_V);
    localparam int NCNT_BITS   = VTX_BITS + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int KEY_BITS    = WEIGHT_BITS + 1;
    localparam int ADJ_ABITS   = 2 * VTX_BITS;
    localparam int ADJ_DEPTH   = 1 << ADJ_ABITS;
    localparam int CFG_BITS    = 7;
    localparam int FUNC_BITS   = 2;

    localparam logic [KEY_BITS-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TREE  = 2'd2;

    typedef struct packed {
        logic                in_tree;
        logic [KEY_BITS-1:0] key;
        logic [VTX_BITS-1:0] parent;
    } t_vtx;

    localparam int VTX_W = $bits(t_vtx);

    // Clamp the configured count into 1 .. MAX_V.
    function automatic logic [NCNT_BITS-1:0] active_count(input logic [CFG_BITS-1:0] cfg);
        logic [NCNT_BITS-1:0] res;
        if (cfg == '0) begin
            res = NCNT_BITS'(1);
        end else if (int'(cfg) > MAX_V) begin
            res = NCNT_BITS'(MAX_V);
        end else begin
            res = NCNT_BITS'(cfg);
        end
        return res;
    endfunction

endpackage

/* rtl/pmst_in_if.sv */
interface pmst_in_if;
    import pmst_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [VTX_BITS-1:0]    src_vertex;
    logic [VTX_BITS-1:0]    dst_vertex;
    logic [WEIGHT_BITS-1:0] edge_weight;

    modport source (output valid, func, src_vertex, dst_vertex, edge_weight, input ready);
    modport sink (input valid, func, src_vertex, dst_vertex, edge_weight, output ready);
endinterface

/* rtl/pmst_out_if.sv */
interface pmst_out_if;
    import pmst_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VTX_BITS-1:0]    parent_vertex;
    logic [VTX_BITS-1:0]    child_vertex;
    logic [WEIGHT_BITS-1:0] tree_weight;
    logic                   reached;
    logic                   last;

    modport source (output valid, parent_vertex, child_vertex, tree_weight, reached, last,
                    input ready);
    modport sink (input valid, parent_vertex, child_vertex, tree_weight, reached, last,
                  output ready);
endinterface

/* rtl/prim_minimum_spanning_tree.sv */
// Minimum spanning tree engine (Prim's algorithm) over an adjacency matrix of
// 64 x 64 weights held in a single-port-write, single-port-read RAM, with a
// second 64-entry RAM holding each vertex's key, parent and tree flag. An add
// transfer writes both symmetric entries; a clear transfer, and reset itself,
// sweep every matrix entry to zero, one entry a cycle, which keeps the input
// not ready until the sweep ends. A compute transfer initializes the vertex
// RAM, then runs up to n-1 passes: one pass reads row "pick" of the matrix
// together with every vertex entry, relaxes the keys, writes them back and
// finds the next pick in the same sweep, so the run is bounded by the one
// read port of the vertex RAM. Results then leave through the output register
// as it frees, vertex 1 to n-1 in order, the last one flagged; an unreachable
// vertex reports reached=0 with zero parent and weight, and a one-vertex graph
// gives a single empty result. The input is ready only between items; the
// output register lets a finished result wait while add or clear transfers go
// on. The user writes num_vertices through i_cfg_we / i_cfg_wdata while the
// block is idle; the block itself does not enforce this.
`include "prim_minimum_spanning_tree_defines.svh"

module prim_minimum_spanning_tree (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pmst_in_if.sink                  i_item,
    pmst_out_if.source               o_res,
    input  logic                     i_cfg_we,
    input  logic [pmst_pkg::CFG_BITS-1:0] i_cfg_wdata
);
    import pmst_pkg::*;

    localparam logic [2:0] S_SWEEP   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_ADD2    = 3'd2;
    localparam logic [2:0] S_INIT    = 3'd3;
    localparam logic [2:0] S_PASS    = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_LD = 3'd6;
    localparam logic [2:0] S_ONE     = 3'd7;

    // Control state
    logic [2:0]             r_state, n_state;
    logic [CFG_BITS-1:0]    r_num_vertices;
    logic [ADJ_ABITS-1:0]   r_sweep, n_sweep;
    logic [VTX_BITS-1:0]    r_add_row, n_add_row;
    logic [VTX_BITS-1:0]    r_add_col, n_add_col;
    logic [WEIGHT_BITS-1:0] r_add_w, n_add_w;
    logic [VTX_BITS-1:0]    r_last_v, n_last_v;
    logic [VTX_BITS-1:0]    r_v, n_v;
    logic                   r_issue, n_issue;
    logic                   r_dv, n_dv;
    logic [VTX_BITS-1:0]    r_wv, n_wv;
    logic [VTX_BITS-1:0]    r_pick, n_pick;
    logic [VTX_BITS-1:0]    r_step, n_step;
    logic [KEY_BITS-1:0]    r_min, n_min;
    logic [VTX_BITS-1:0]    r_mpick, n_mpick;
    logic                   r_mfound, n_mfound;

    // Output register
    logic                   r_ov, n_ov;
    logic [VTX_BITS-1:0]    r_o_parent, n_o_parent;
    logic [VTX_BITS-1:0]    r_o_child, n_o_child;
    logic [WEIGHT_BITS-1:0] r_o_weight, n_o_weight;
    logic                   r_o_reached, n_o_reached;
    logic                   r_o_last, n_o_last;

    // RAM ports
    logic                   adj_we, adj_re;
    logic [ADJ_ABITS-1:0]   adj_waddr, adj_raddr;
    logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata;
    logic                   vtx_we, vtx_re;
    logic [VTX_BITS-1:0]    vtx_waddr, vtx_raddr;
    t_vtx                   vtx_wdata, vtx_rdata;

    // Pass datapath
    logic                   in_xfer;
    logic                   out_free;
    logic [NCNT_BITS-1:0]   cnt;
    logic                   p_in, p_upd, p_cand;
    t_vtx                   p_new;
    logic [KEY_BITS-1:0]    c_min;
    logic [VTX_BITS-1:0]    c_mpick;
    logic                   c_mfound;
    logic                   e_reached;

    assign in_xfer       = i_item.valid && i_item.ready;
    assign i_item.ready  = (r_state == S_IDLE);
    assign out_free      = !r_ov || o_res.ready;
    assign cnt           = active_count(r_num_vertices);

    assign o_res.valid         = r_ov;
    assign o_res.parent_vertex = r_o_parent;
    assign o_res.child_vertex  = r_o_child;
    assign o_res.tree_weight   = r_o_weight;
    assign o_res.reached       = r_o_reached;
    assign o_res.last          = r_o_last;

    pmst_ram #(.DEPTH(ADJ_DEPTH), .WIDTH(WEIGHT_BITS)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    pmst_ram #(.DEPTH(MAX_V), .WIDTH(VTX_W)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (vtx_waddr),
        .i_wdata (vtx_wdata),
        .i_re    (vtx_re),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    // Relax one vertex against the current pick; the pick itself joins the tree
    // here, and the running minimum over the updated keys names the next pick.
    always_comb begin
        p_in           = vtx_rdata.in_tree || (r_wv == r_pick);
        p_upd          = (adj_rdata != '0) && !p_in && ({1'b0, adj_rdata} < vtx_rdata.key);
        p_new.in_tree  = p_in;
        p_new.key      = p_upd ? {1'b0, adj_rdata} : vtx_rdata.key;
        p_new.parent   = p_upd ? r_pick : vtx_rdata.parent;
        p_cand         = !p_in && (p_new.key < r_min);
        c_min          = p_cand ? p_new.key : r_min;
        c_mpick        = p_cand ? r_wv : r_mpick;
        c_mfound       = p_cand || r_mfound;
        // A finite key at emit time means the vertex made it into the tree.
        e_reached      = !vtx_rdata.key[KEY_BITS-1];
    end

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_add_row   = r_add_row;
        n_add_col   = r_add_col;
        n_add_w     = r_add_w;
        n_last_v    = r_last_v;
        n_v         = r_v;
        n_issue     = r_issue;
        n_dv        = 1'b0;
        n_wv        = r_wv;
        n_pick      = r_pick;
        n_step      = r_step;
        n_min       = r_min;
        n_mpick     = r_mpick;
        n_mfound    = r_mfound;
        n_ov        = r_ov && !o_res.ready;
        n_o_parent  = r_o_parent;
        n_o_child   = r_o_child;
        n_o_weight  = r_o_weight;
        n_o_reached = r_o_reached;
        n_o_last    = r_o_last;

        adj_we      = 1'b0;
        adj_waddr   = r_sweep;
        adj_wdata   = '0;
        adj_re      = 1'b0;
        adj_raddr   = {r_pick, r_v};
        vtx_we      = 1'b0;
        vtx_waddr   = r_v;
        vtx_wdata.in_tree = 1'b0;
        vtx_wdata.key     = (r_v == '0) ? '0 : KEY_INF;
        vtx_wdata.parent  = '0;
        vtx_re      = 1'b0;
        vtx_raddr   = r_v;

        case (r_state)
            S_SWEEP: begin
                // Zero one matrix entry a cycle.
                adj_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_item.func)
                        FUNC_ADD: begin
                            adj_we    = 1'b1;
                            adj_waddr = {i_item.src_vertex, i_item.dst_vertex};
                            adj_wdata = i_item.edge_weight;
                            n_add_row = i_item.dst_vertex;
                            n_add_col = i_item.src_vertex;
                            n_add_w   = i_item.edge_weight;
                            n_state   = S_ADD2;
                        end
                        FUNC_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        FUNC_TREE: begin
                            n_last_v = VTX_BITS'(cnt - 1'b1);
                            n_v      = '0;
                            n_state  = (cnt == NCNT_BITS'(1)) ? S_ONE : S_INIT;
                        end
                        default: begin
                            // Drop the unused code.
                        end
                    endcase
                end
            end
            S_ADD2: begin
                // Mirror entry of the edge.
                adj_we    = 1'b1;
                adj_waddr = {r_add_row, r_add_col};
                adj_wdata = r_add_w;
                n_state   = S_IDLE;
            end
            S_INIT: begin
                vtx_we = 1'b1;
                if (r_v == r_last_v) begin
                    n_v      = '0;
                    n_pick   = '0;
                    n_step   = '0;
                    n_issue  = 1'b1;
                    n_min    = KEY_INF;
                    n_mfound = 1'b0;
                    n_state  = S_PASS;
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            S_PASS: begin
                // Issue side: one vertex and one matrix entry per cycle.
                if (r_issue) begin
                    adj_re = 1'b1;
                    vtx_re = 1'b1;
                    n_dv   = 1'b1;
                    n_wv   = r_v;
                    if (r_v == r_last_v) begin
                        n_issue = 1'b0;
                    end else begin
                        n_v = r_v + 1'b1;
                    end
                end
                // Write-back side, one entry behind the issue side.
                if (r_dv) begin
                    vtx_we    = 1'b1;
                    vtx_waddr = r_wv;
                    vtx_wdata = p_new;
                    n_min     = c_min;
                    n_mpick   = c_mpick;
                    n_mfound  = c_mfound;
                    if (r_wv == r_last_v) begin
                        if ((r_step + 1'b1 == r_last_v) || !c_mfound) begin
                            n_v     = VTX_BITS'(1);
                            n_state = S_EMIT_RD;
                        end else begin
                            n_pick   = c_mpick;
                            n_step   = r_step + 1'b1;
                            n_v      = '0;
                            n_issue  = 1'b1;
                            n_min    = KEY_INF;
                            n_mfound = 1'b0;
                        end
                    end
                end
            end
            S_EMIT_RD: begin
                vtx_re  = 1'b1;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                // Hold until the output register frees up.
                if (out_free) begin
                    n_ov        = 1'b1;
                    n_o_parent  = e_reached ? vtx_rdata.parent : '0;
                    n_o_child   = r_v;
                    n_o_weight  = e_reached ? vtx_rdata.key[WEIGHT_BITS-1:0] : '0;
                    n_o_reached = e_reached;
                    n_o_last    = (r_v == r_last_v);
                    if (r_v == r_last_v) begin
                        n_state = S_IDLE;
                    end else begin
                        n_v     = r_v + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_ONE: begin
                // Single-vertex graph: one empty result.
                if (out_free) begin
                    n_ov        = 1'b1;
                    n_o_parent  = '0;
                    n_o_child   = '0;
                    n_o_weight  = '0;
                    n_o_reached = 1'b0;
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_SWEEP;
            r_num_vertices <= CFG_BITS'(MAX_V);
            r_sweep        <= '0;
            r_issue        <= 1'b0;
            r_dv           <= 1'b0;
            r_ov           <= 1'b0;
            r_v            <= '0;
            r_step         <= '0;
            r_mfound       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_issue  <= n_issue;
            r_dv     <= n_dv;
            r_ov     <= n_ov;
            r_v      <= n_v;
            r_step   <= n_step;
            r_mfound <= n_mfound;
            if (i_cfg_we) begin
                r_num_vertices <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_add_row   <= n_add_row;
        r_add_col   <= n_add_col;
        r_add_w     <= n_add_w;
        r_last_v    <= n_last_v;
        r_wv        <= n_wv;
        r_pick      <= n_pick;
        r_min       <= n_min;
        r_mpick     <= n_mpick;
        r_o_parent  <= n_o_parent;
        r_o_child   <= n_o_child;
        r_o_weight  <= n_o_weight;
        r_o_reached <= n_o_reached;
        r_o_last    <= n_o_last;
    end

    `PMST_ASSERT_IMP(a_pass_in_range, i_clk, i_rst_n, r_dv, r_wv <= r_last_v)
    `PMST_ASSERT_IMP(a_vtx_no_overlap, i_clk, i_rst_n, vtx_we && vtx_re, vtx_waddr != vtx_raddr)
    `PMST_ASSERT_NXT(a_tree_busy, i_clk, i_rst_n, in_xfer && (i_item.func == FUNC_TREE), !i_item.ready)
    `PMST_ASSERT_IMP(a_unreached_empty, i_clk, i_rst_n, r_ov && !r_o_reached, (r_o_weight == '0) && (r_o_parent == '0))
endmodule

/* rtl/pmst_ram.sv */
module pmst_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Spanning tree engine check: drive edge, clear and tree transfers, grow the
// expected tree in a local Prim search, and compare every emitted row.
module testbench;
    import pmst_pkg::*;

    // Spare function code; the block must swallow it without output.
    localparam logic [FUNC_BITS-1:0] FUNC_NONE = 2'd3;

    localparam int CYCLE_LIMIT   = 4_000_000;
    // Longest quiet work after the last row: a full matrix clear sweep.
    localparam int SETTLE_CYCLES = 4200;
    localparam int RX_LONG_HOLD  = 3000;
    localparam int NROWS         = 26;

    typedef struct packed {
        logic [VTX_BITS-1:0]    parent;
        logic [VTX_BITS-1:0]    child;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   reached;
        logic                   last;
    } t_tree_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One directed step: an item, or a vertex count write (value in weight).
    typedef struct packed {
        t_row_kind              kind;
        logic [FUNC_BITS-1:0]   func;
        logic [VTX_BITS-1:0]    src;
        logic [VTX_BITS-1:0]    dst;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   typed;
        t_tree_res              want;
    } t_plan_row;

    localparam t_tree_res NO_ROW     = '0;
    localparam t_tree_res LONE_ROW   = '{6'd0, 6'd0, 16'd0, 1'b0, 1'b1};
    localparam t_tree_res CUT_ROW    = '{6'd0, 6'd1, 16'd0, 1'b0, 1'b1};
    localparam t_tree_res HEAVY_ROW  = '{6'd0, 6'd1, 16'hFFFF, 1'b1, 1'b1};
    localparam t_tree_res LIGHT_ROW  = '{6'd0, 6'd1, 16'd1, 1'b1, 1'b1};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_wdata;

    pmst_in_if  item_if ();
    pmst_out_if res_if ();

    prim_minimum_spanning_tree dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Local image of the block: matrix, vertex count, and rows still owed.
    logic [WEIGHT_BITS-1:0] edge_w [ADJ_DEPTH];
    logic [CFG_BITS-1:0]    vtx_cfg;
    t_tree_res              tree_q [$];

    int fail_count = 0;
    int cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_hold_req = 0;

    // Directed walk. Typed rows carry the single row a one- or two-vertex
    // graph must give; the rest lean on the local search.
    t_plan_row plan [NROWS] = '{
        // matrix cleared by reset: all 63 vertices cut off
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b0, NO_ROW},
        '{ROW_CFG,  FUNC_ADD,   6'd0,  6'd0,  16'd2,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, CUT_ROW},
        '{ROW_ITEM, FUNC_ADD,   6'd0,  6'd1,  16'hFFFF,  1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, HEAVY_ROW},
        // reversed endpoints overwrite the same edge
        '{ROW_ITEM, FUNC_ADD,   6'd1,  6'd0,  16'd1,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, LIGHT_ROW},
        // self loop, then weight 0 drops the edge
        '{ROW_ITEM, FUNC_ADD,   6'd1,  6'd1,  16'd7,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_ADD,   6'd0,  6'd1,  16'd0,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, CUT_ROW},
        // edge stored beyond the live count, spare code with all bits high
        '{ROW_ITEM, FUNC_ADD,   6'd63, 6'd62, 16'd9,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_NONE,  6'd63, 6'd63, 16'hFFFF,  1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, CUT_ROW},
        // count 0 acts as one vertex
        '{ROW_CFG,  FUNC_ADD,   6'd0,  6'd0,  16'd0,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, LONE_ROW},
        '{ROW_CFG,  FUNC_ADD,   6'd0,  6'd0,  16'd1,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b1, LONE_ROW},
        // count above the matrix acts as the full 64
        '{ROW_CFG,  FUNC_ADD,   6'd0,  6'd0,  16'd127,   1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_ADD,   6'd0,  6'd63, 16'h8000,  1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_ADD,   6'd5,  6'd6,  16'd3,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_CLEAR, 6'd0,  6'd0,  16'd0,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b0, NO_ROW},
        // five live vertices, only edge 0-2 after the clear: the rest are cut off
        '{ROW_CFG,  FUNC_ADD,   6'd0,  6'd0,  16'd5,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_ADD,   6'd0,  6'd2,  16'd2,     1'b0, NO_ROW},
        '{ROW_ITEM, FUNC_TREE,  6'd0,  6'd0,  16'd0,     1'b0, NO_ROW}
    };

    function automatic int live_count(input logic [CFG_BITS-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n < 1) n = 1;
        if (n > MAX_V) n = MAX_V;
        return n;
    endfunction

    // Grow the tree from vertex 0 and queue one row per vertex 1 .. n-1.
    function automatic void grow_tree();
        logic [KEY_BITS-1:0]    key [MAX_V];
        logic [VTX_BITS-1:0]    par [MAX_V];
        bit                     joined [MAX_V];
        logic [KEY_BITS-1:0]    min_key;
        logic [WEIGHT_BITS-1:0] w;
        t_tree_res              r;
        int                     n, v, step, pick;
        bit                     stuck;
        n = live_count(vtx_cfg);
        if (n == 1) begin
            r = '0;
            r.last = 1'b1;
            tree_q.push_back(r);
            return;
        end
        for (v = 0; v < n; v++) begin
            key[v] = KEY_INF;
            par[v] = '0;
            joined[v] = 1'b0;
        end
        key[0] = '0;
        stuck = 1'b0;
        for (step = 0; step + 1 < n && !stuck; step++) begin
            min_key = KEY_INF;
            pick = -1;
            // strict compare: ties keep the lowest index
            for (v = 0; v < n; v++) begin
                if (!joined[v] && key[v] < min_key) begin
                    min_key = key[v];
                    pick = v;
                end
            end
            if (pick < 0) begin
                stuck = 1'b1;
            end else begin
                joined[pick] = 1'b1;
                for (v = 0; v < n; v++) begin
                    w = edge_w[pick * MAX_V + v];
                    if (w != '0 && !joined[v] && {1'b0, w} < key[v]) begin
                        par[v] = VTX_BITS'(pick);
                        key[v] = {1'b0, w};
                    end
                end
            end
        end
        // the final pick is never taken inside the loop; join it here
        for (v = 1; v < n; v++) begin
            if (!joined[v] && key[v] < KEY_INF) joined[v] = 1'b1;
        end
        for (v = 1; v < n; v++) begin
            r.parent  = joined[v] ? par[v] : '0;
            r.child   = VTX_BITS'(v);
            r.weight  = joined[v] ? key[v][WEIGHT_BITS-1:0] : '0;
            r.reached = joined[v];
            r.last    = (v + 1 == n);
            tree_q.push_back(r);
        end
    endfunction

    function automatic void apply_item(input logic [FUNC_BITS-1:0] func,
                                       input logic [VTX_BITS-1:0] s, d,
                                       input logic [WEIGHT_BITS-1:0] w);
        case (func)
            FUNC_ADD: begin
                edge_w[{s, d}] = w;
                edge_w[{d, s}] = w;
            end
            FUNC_CLEAR: begin
                edge_w = '{default: '0};
            end
            FUNC_TREE: begin
                grow_tree();
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_result(input t_tree_res want, input t_tree_res got);
        if (got.parent !== want.parent) begin
            $error("parent_vertex: expected %0d, actual %0d", want.parent, got.parent);
            fail_count++;
        end
        if (got.child !== want.child) begin
            $error("child_vertex: expected %0d, actual %0d", want.child, got.child);
            fail_count++;
        end
        if (got.weight !== want.weight) begin
            $error("tree_weight: expected %0d, actual %0d", want.weight, got.weight);
            fail_count++;
        end
        if (got.reached !== want.reached) begin
            $error("reached: expected %0d, actual %0d", want.reached, got.reached);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    // Offer one item after a random gap; predict once the transfer lands.
    // Called and returns at a falling edge, valid left high for a
    // back-to-back follower.
    task automatic send_item(input logic [FUNC_BITS-1:0] func,
                             input logic [VTX_BITS-1:0] s, d,
                             input logic [WEIGHT_BITS-1:0] w);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            item_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.func        = func;
        item_if.src_vertex  = s;
        item_if.dst_vertex  = d;
        item_if.edge_weight = w;
        item_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        apply_item(func, s, d, w);
        @(negedge i_clk);
    endtask

    // Drain owed rows, then sit out the longest silent work (a clear sweep).
    task automatic settle();
        item_if.valid = 1'b0;
        while (tree_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [CFG_BITS-1:0] value);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        vtx_cfg     = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Mostly edges among live vertices, with chain links to connect graphs,
    // plenty of small weights for ties, and now and then a tree, a clear or
    // noise. Halfway through, hold the sender until every row is back. With
    // the long hold, open on a tree so that its rows back up into the block.
    task automatic random_phase(input logic [CFG_BITS-1:0] cfg, input int nitems,
                                input bit long_hold);
        int n, k, op, pick_w;
        logic [VTX_BITS-1:0]    s, d;
        logic [WEIGHT_BITS-1:0] w;
        write_vertex_count(cfg);
        n = live_count(cfg);
        if (long_hold) rx_hold_req = RX_LONG_HOLD;
        for (k = 0; k < nitems; k++) begin
            if (k == nitems / 2) begin
                item_if.valid = 1'b0;
                while (tree_q.size() != 0) @(negedge i_clk);
            end
            s = ($urandom_range(0, 6) == 0) ? VTX_BITS'($urandom)
                                            : VTX_BITS'($urandom_range(0, n - 1));
            if ($urandom_range(0, 6) == 0) begin
                d = VTX_BITS'($urandom);
            end else if ($urandom_range(0, 1) == 0) begin
                d = VTX_BITS'((int'(s) + 1) % n);
            end else begin
                d = VTX_BITS'($urandom_range(0, n - 1));
            end
            pick_w = $urandom_range(0, 9);
            if (pick_w < 4) begin
                w = WEIGHT_BITS'($urandom_range(1, 4));
            end else if (pick_w < 8) begin
                w = WEIGHT_BITS'($urandom);
            end else if (pick_w == 8) begin
                w = '0;
            end else begin
                w = '1;
            end
            op = (long_hold && k == 0) ? 99 : $urandom_range(0, 99);
            if (op < 72) begin
                send_item(FUNC_ADD, s, d, w);
            end else if (op < 75) begin
                send_item(FUNC_CLEAR, s, d, w);
            end else if (op < 78) begin
                send_item(FUNC_NONE, s, d, w);
            end else begin
                send_item(FUNC_TREE, s, d, w);
            end
        end
    endtask

    // Result side: random ready gaps, one long hold on request, and a check
    // of every transfer against the oldest owed row.
    initial begin : result_sink
        int        gap;
        t_tree_res got;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (gap != 0) begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got = '{res_if.parent_vertex, res_if.child_vertex, res_if.tree_weight,
                    res_if.reached, res_if.last};
            if (tree_q.size() == 0) begin
                $error("unexpected result: child_vertex %0d", got.child);
                fail_count++;
            end else begin
                check_result(tree_q.pop_front(), got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        item_if.valid       = 1'b0;
        item_if.func        = FUNC_ADD;
        item_if.src_vertex  = '0;
        item_if.dst_vertex  = '0;
        item_if.edge_weight = '0;
        edge_w              = '{default: '0};
        vtx_cfg             = CFG_BITS'(MAX_V);

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < NROWS; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                write_vertex_count(plan[i].weight[CFG_BITS-1:0]);
            end else begin
                send_item(plan[i].func, plan[i].src, plan[i].dst, plan[i].weight);
                // swap in the row typed in the table for the predicted one
                if (plan[i].typed) begin
                    void'(tree_q.pop_back());
                    tree_q.push_back(plan[i].want);
                end
            end
        end

        // small graphs dominate; the full 64 appears twice
        random_phase(7'd4,   21, 1'b0);
        random_phase(7'd8,   21, 1'b1);
        random_phase(7'd3,   21, 1'b0);
        random_phase(7'd16,  21, 1'b0);
        random_phase(7'd64,  21, 1'b0);
        random_phase(7'd6,   21, 1'b0);
        random_phase(7'd100, 21, 1'b0);
        random_phase(7'd12,  21, 1'b0);
        random_phase(7'd2,   21, 1'b0);
        random_phase(7'd33,  21, 1'b0);

        settle();
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
